[hdl/camob_pkg.sv]
// constants, widths and series divisor table for the camera orientation basis core
package camob_pkg;

  localparam int unsigned ANGLE_FRAC_BITS  = 7;
  localparam int unsigned VECTOR_FRAC_BITS = 15;
  localparam int unsigned FIELD_W          = 16;

  localparam int unsigned QUARTER_TURN = 90 << ANGLE_FRAC_BITS;
  localparam int unsigned HALF_TURN    = 180 << ANGLE_FRAC_BITS;
  localparam int unsigned FULL_TURN    = 360 << ANGLE_FRAC_BITS;
  localparam int unsigned PITCH_LIMIT  = 89 << ANGLE_FRAC_BITS;
  localparam int unsigned YAW_RESET    = 270 << ANGLE_FRAC_BITS;

  localparam int unsigned YAW_W   = $clog2(FULL_TURN);
  localparam int unsigned QA_W    = $clog2(QUARTER_TURN);
  localparam int unsigned PITCH_W = $clog2(PITCH_LIMIT + 1) + 1;
  localparam int unsigned YSUM_W  = $clog2(FULL_TURN + 32768) + 1;
  localparam int unsigned PSUM_W  = $clog2(PITCH_LIMIT + 32769) + 1;

  localparam int unsigned TRIG_W = 32;
  localparam int unsigned PROD_W = 2 * TRIG_W;
  localparam int unsigned Q_FRAC = 30;
  localparam logic [TRIG_W-1:0] ONE_Q30 = 32'h4000_0000;
  localparam logic [TRIG_W-1:0] PI_Q30  = 32'd3373259426;

  localparam int unsigned DIV_BITS   = 8;
  localparam int unsigned DIV_STEPS  = (QA_W + TRIG_W + DIV_BITS - 1) / DIV_BITS;
  localparam int unsigned DIV_W      = DIV_STEPS * DIV_BITS;
  localparam int unsigned TERM_STEPS = TRIG_W / DIV_BITS;
  localparam int unsigned DVR_W      = $clog2(HALF_TURN + 1);
  localparam int unsigned DCNT_W     = $clog2(DIV_STEPS + 1);

  localparam int unsigned SIN_TERMS = 7;
  localparam int unsigned COS_TERMS = 8;
  localparam int unsigned N_W       = 4;

  localparam int unsigned NUM_OUT    = 8;
  localparam int unsigned IDX_W      = $clog2(NUM_OUT);
  localparam int unsigned RND_SH     = 2 * Q_FRAC - VECTOR_FRAC_BITS;
  localparam int unsigned MAGR_W     = PROD_W + 1 - RND_SH;
  localparam int unsigned OUT_HI     = ((1 << VECTOR_FRAC_BITS) - 1 > 32767) ?
                                       32767 : (1 << VECTOR_FRAC_BITS) - 1;
  localparam int unsigned OUT_LO_MAG = ((1 << VECTOR_FRAC_BITS) > 32768) ?
                                       32768 : (1 << VECTOR_FRAC_BITS);

  // k(k+1) divisor of the n-th taylor term
  function automatic logic [7:0] taylor_div(input logic cos_ser, input logic [N_W-1:0] n);
    logic [7:0] d;
    d = 8'd1;
    if (cos_ser) begin
      unique case (n)
        4'd1: d = 8'd2;
        4'd2: d = 8'd12;
        4'd3: d = 8'd30;
        4'd4: d = 8'd56;
        4'd5: d = 8'd90;
        4'd6: d = 8'd132;
        4'd7: d = 8'd182;
        4'd8: d = 8'd240;
        default: d = 8'd1;
      endcase
    end else begin
      unique case (n)
        4'd1: d = 8'd6;
        4'd2: d = 8'd20;
        4'd3: d = 8'd42;
        4'd4: d = 8'd72;
        4'd5: d = 8'd110;
        4'd6: d = 8'd156;
        4'd7: d = 8'd210;
        default: d = 8'd1;
      endcase
    end
    return d;
  endfunction

endpackage

[hdl/camera_orientation_basis_core.sv]
// camera orientation basis core: yaw/pitch accumulation and fixed-point camera basis
// Usage:
//   input channel (in_valid, in_stall, yaw_delta, pitch_delta): one transfer adds the
//   deltas to the stored yaw and pitch. in_stall is high while an item is being worked.
//   output channel (out_valid, out_stall, forward/right/up fields, pitch_clamped): one
//   result per input, held stable while out_stall is high.
//   the core works one item at a time: in_stall stays high until the result moves to the
//   output register. The work is set by one shared 32x32 multiplier and an
//   8-bit-per-cycle divider working through 15 taylor terms for each of the two angles,
//   plus 8 output products.
//   a finished result sits in the output register; the next input is taken meanwhile,
//   and the core only waits at its last step if the previous result is still stalled.
//   reset: yaw returns to 270 degrees, pitch to zero, no result pending.
module camera_orientation_basis_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [camob_pkg::FIELD_W-1:0] yaw_delta,
  input  logic signed [camob_pkg::FIELD_W-1:0] pitch_delta,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [camob_pkg::FIELD_W-1:0] forward_x,
  output logic signed [camob_pkg::FIELD_W-1:0] forward_y,
  output logic signed [camob_pkg::FIELD_W-1:0] forward_z,
  output logic signed [camob_pkg::FIELD_W-1:0] right_x,
  output logic signed [camob_pkg::FIELD_W-1:0] right_z,
  output logic signed [camob_pkg::FIELD_W-1:0] up_x,
  output logic signed [camob_pkg::FIELD_W-1:0] up_y,
  output logic signed [camob_pkg::FIELD_W-1:0] up_z,
  output logic                                 pitch_clamped
);
  import camob_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_WRAP  = 3'd1;
  localparam logic [2:0] ST_MWAIT = 3'd2;
  localparam logic [2:0] ST_MUSE  = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_DDONE = 3'd5;
  localparam logic [2:0] ST_OLOAD = 3'd6;
  localparam logic [2:0] ST_FLUSH = 3'd7;

  localparam logic [1:0] P_ANGLE = 2'd0;
  localparam logic [1:0] P_SQ    = 2'd1;
  localparam logic [1:0] P_TERM  = 2'd2;
  localparam logic [1:0] P_OUT   = 2'd3;

  localparam logic signed [YSUM_W-1:0]  Y_FULL = YSUM_W'(FULL_TURN);
  localparam logic signed [PSUM_W-1:0]  P_MAX  = PSUM_W'(PITCH_LIMIT);
  localparam logic signed [PITCH_W-1:0] P_LIM  = PITCH_W'(PITCH_LIMIT);
  localparam logic [YAW_W-1:0] Q1 = YAW_W'(QUARTER_TURN);
  localparam logic [YAW_W-1:0] Q2 = YAW_W'(2 * QUARTER_TURN);
  localparam logic [YAW_W-1:0] Q3 = YAW_W'(3 * QUARTER_TURN);

  logic [2:0] state;
  logic [1:0] purpose;

  logic [YAW_W-1:0]          yaw;
  logic signed [PITCH_W-1:0] pitch;
  logic                      clamp_flag;
  logic signed [YSUM_W-1:0]  yaw_sum;
  logic [1:0]                quad;
  logic                      angle_pitch;

  logic signed [YSUM_W-1:0]  ysum_next;
  logic signed [PSUM_W-1:0]  psum;
  logic signed [PITCH_W-1:0] pitch_next;
  logic                      clamp_next;
  logic [YAW_W-1:0]          yaw_u;
  logic [1:0]                quad_next;
  logic [QA_W-1:0]           qrem_next;
  logic [PITCH_W-1:0]        pmag;

  logic [TRIG_W-1:0] mul_a;
  logic [TRIG_W-1:0] mul_b;
  logic [PROD_W-1:0] prod;

  logic [DIV_W-1:0]    div_reg;
  logic [DVR_W-1:0]    divisor;
  logic [DVR_W-1:0]    rem;
  logic [DVR_W-1:0]    rem_c;
  logic [DVR_W:0]      div_trial;
  logic [DIV_BITS-1:0] q_c;
  logic [DCNT_W-1:0]   div_cnt;
  logic [TRIG_W-1:0]   quot;

  logic [TRIG_W-1:0]        x;
  logic [TRIG_W-1:0]        x2;
  logic signed [TRIG_W-1:0] acc;
  logic signed [TRIG_W-1:0] acc_next;
  logic signed [TRIG_W-1:0] s_val;
  logic signed [TRIG_W-1:0] sy;
  logic signed [TRIG_W-1:0] cy;
  logic signed [TRIG_W-1:0] sp;
  logic signed [TRIG_W-1:0] cp;
  logic                     cos_ser;
  logic [N_W-1:0]           n;
  logic                     last_term;

  logic [IDX_W-1:0]         idx;
  logic                     out_neg;
  logic signed [TRIG_W-1:0] op_a;
  logic signed [TRIG_W-1:0] op_b;
  logic                     op_neg;
  logic [TRIG_W-1:0]        mag_a;
  logic [TRIG_W-1:0]        mag_b;
  logic [PROD_W:0]          rnd;
  logic [MAGR_W-1:0]        magr;
  logic [FIELD_W-1:0]       qval;
  logic [FIELD_W-1:0]       res_buf [NUM_OUT];

  assign in_stall = (state != ST_IDLE);

  // angle update
  always_comb begin
    ysum_next = YSUM_W'($signed({1'b0, yaw})) + YSUM_W'(yaw_delta);
    psum = PSUM_W'(pitch) + PSUM_W'(pitch_delta);
    clamp_next = 1'b0;
    pitch_next = PITCH_W'(psum);
    if (psum > P_MAX) begin
      pitch_next = P_LIM;
      clamp_next = 1'b1;
    end else if (psum < -P_MAX) begin
      pitch_next = -P_LIM;
      clamp_next = 1'b1;
    end
  end

  // quadrant split of the wrapped yaw
  always_comb begin
    yaw_u = yaw_sum[YAW_W-1:0];
    priority if (yaw_u >= Q3) begin
      quad_next = 2'd3;
      qrem_next = QA_W'(yaw_u - Q3);
    end else if (yaw_u >= Q2) begin
      quad_next = 2'd2;
      qrem_next = QA_W'(yaw_u - Q2);
    end else if (yaw_u >= Q1) begin
      quad_next = 2'd1;
      qrem_next = QA_W'(yaw_u - Q1);
    end else begin
      quad_next = 2'd0;
      qrem_next = QA_W'(yaw_u);
    end
  end

  assign pmag = pitch[PITCH_W-1] ? PITCH_W'(-pitch) : PITCH_W'(pitch);

  // restoring divider, several quotient bits per cycle
  always_comb begin
    rem_c = rem;
    q_c = '0;
    div_trial = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      div_trial = {rem_c, div_reg[DIV_W-1-i]};
      if (div_trial >= {1'b0, divisor}) begin
        rem_c = DVR_W'(div_trial - {1'b0, divisor});
        q_c[DIV_BITS-1-i] = 1'b1;
      end else begin
        rem_c = div_trial[DVR_W-1:0];
      end
    end
  end

  assign quot = div_reg[TRIG_W-1:0];
  assign acc_next = n[0] ? acc - $signed(quot) : acc + $signed(quot);
  assign last_term = cos_ser ? (n == N_W'(COS_TERMS)) : (n == N_W'(SIN_TERMS));

  // operands of each basis component
  always_comb begin
    unique case (idx)
      3'd0: begin op_a = cy; op_b = cp;               op_neg = 1'b0; end
      3'd1: begin op_a = sp; op_b = $signed(ONE_Q30); op_neg = 1'b0; end
      3'd2: begin op_a = sy; op_b = cp;               op_neg = 1'b0; end
      3'd3: begin op_a = sy; op_b = $signed(ONE_Q30); op_neg = 1'b1; end
      3'd4: begin op_a = cy; op_b = $signed(ONE_Q30); op_neg = 1'b0; end
      3'd5: begin op_a = cy; op_b = sp;               op_neg = 1'b1; end
      3'd6: begin op_a = cp; op_b = $signed(ONE_Q30); op_neg = 1'b0; end
      3'd7: begin op_a = sy; op_b = sp;               op_neg = 1'b1; end
      default: begin op_a = '0; op_b = '0; op_neg = 1'b0; end
    endcase
    mag_a = op_a[TRIG_W-1] ? $unsigned(-op_a) : $unsigned(op_a);
    mag_b = op_b[TRIG_W-1] ? $unsigned(-op_b) : $unsigned(op_b);
  end

  // round half away from zero and saturate
  always_comb begin
    rnd = {1'b0, prod} + ((PROD_W + 1)'(1) << (RND_SH - 1));
    magr = rnd[PROD_W:RND_SH];
    if (out_neg) begin
      if (magr > MAGR_W'(OUT_LO_MAG)) begin
        qval = FIELD_W'(-OUT_LO_MAG);
      end else begin
        qval = -(FIELD_W'(magr));
      end
    end else begin
      if (magr > MAGR_W'(OUT_HI)) begin
        qval = FIELD_W'(OUT_HI);
      end else begin
        qval = FIELD_W'(magr);
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      yaw       <= YAW_W'(YAW_RESET);
      pitch     <= '0;
    end else begin
      if (out_valid && !out_stall && (state != ST_FLUSH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            yaw_sum    <= ysum_next;
            pitch      <= pitch_next;
            clamp_flag <= clamp_next;
            state      <= ST_WRAP;
          end
        end
        ST_WRAP: begin
          if (yaw_sum[YSUM_W-1]) begin
            yaw_sum <= yaw_sum + Y_FULL;
          end else if (yaw_sum >= Y_FULL) begin
            yaw_sum <= yaw_sum - Y_FULL;
          end else begin
            yaw         <= yaw_u;
            quad        <= quad_next;
            mul_a       <= TRIG_W'(qrem_next);
            mul_b       <= PI_Q30;
            angle_pitch <= 1'b0;
            purpose     <= P_ANGLE;
            state       <= ST_MWAIT;
          end
        end
        ST_MWAIT: begin
          state <= ST_MUSE;
        end
        ST_MUSE: begin
          unique case (purpose)
            P_ANGLE: begin
              div_reg <= prod[DIV_W-1:0];
              divisor <= DVR_W'(HALF_TURN);
              rem     <= '0;
              div_cnt <= DCNT_W'(DIV_STEPS);
              state   <= ST_DIV;
            end
            P_SQ: begin
              x2      <= prod[Q_FRAC+TRIG_W-1:Q_FRAC];
              acc     <= $signed(x);
              n       <= N_W'(1);
              cos_ser <= 1'b0;
              mul_a   <= x;
              mul_b   <= prod[Q_FRAC+TRIG_W-1:Q_FRAC];
              purpose <= P_TERM;
              state   <= ST_MWAIT;
            end
            P_TERM: begin
              div_reg <= {prod[Q_FRAC+TRIG_W-1:Q_FRAC], (DIV_W - TRIG_W)'(0)};
              divisor <= DVR_W'(taylor_div(cos_ser, n));
              rem     <= '0;
              div_cnt <= DCNT_W'(TERM_STEPS);
              state   <= ST_DIV;
            end
            P_OUT: begin
              res_buf[idx] <= qval;
              if (idx == IDX_W'(NUM_OUT - 1)) begin
                state <= ST_FLUSH;
              end else begin
                idx   <= idx + 1'b1;
                state <= ST_OLOAD;
              end
            end
            default: state <= ST_IDLE;
          endcase
        end
        ST_DIV: begin
          div_reg <= {div_reg[DIV_W-DIV_BITS-1:0], q_c};
          rem     <= rem_c;
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == DCNT_W'(1)) begin
            state <= ST_DDONE;
          end
        end
        ST_DDONE: begin
          if (purpose == P_ANGLE) begin
            x       <= quot;
            mul_a   <= quot;
            mul_b   <= quot;
            purpose <= P_SQ;
            state   <= ST_MWAIT;
          end else if (!last_term) begin
            acc   <= acc_next;
            n     <= n + 1'b1;
            mul_a <= quot;
            mul_b <= x2;
            state <= ST_MWAIT;
          end else if (!cos_ser) begin
            s_val   <= acc_next;
            cos_ser <= 1'b1;
            n       <= N_W'(1);
            acc     <= $signed(ONE_Q30);
            mul_a   <= ONE_Q30;
            mul_b   <= x2;
            state   <= ST_MWAIT;
          end else if (!angle_pitch) begin
            unique case (quad)
              2'd0: begin sy <= s_val;     cy <= acc_next;  end
              2'd1: begin sy <= acc_next;  cy <= -s_val;    end
              2'd2: begin sy <= -s_val;    cy <= -acc_next; end
              2'd3: begin sy <= -acc_next; cy <= s_val;     end
              default: begin sy <= s_val;  cy <= acc_next;  end
            endcase
            angle_pitch <= 1'b1;
            mul_a       <= TRIG_W'(pmag);
            mul_b       <= PI_Q30;
            purpose     <= P_ANGLE;
            state       <= ST_MWAIT;
          end else begin
            sp    <= pitch[PITCH_W-1] ? -s_val : s_val;
            cp    <= acc_next;
            idx   <= '0;
            state <= ST_OLOAD;
          end
        end
        ST_OLOAD: begin
          mul_a   <= mag_a;
          mul_b   <= mag_b;
          out_neg <= op_neg ^ op_a[TRIG_W-1] ^ op_b[TRIG_W-1];
          purpose <= P_OUT;
          state   <= ST_MWAIT;
        end
        ST_FLUSH: begin
          if (!out_valid || !out_stall) begin
            forward_x     <= res_buf[0];
            forward_y     <= res_buf[1];
            forward_z     <= res_buf[2];
            right_x       <= res_buf[3];
            right_z       <= res_buf[4];
            up_x          <= res_buf[5];
            up_y          <= res_buf[6];
            up_z          <= res_buf[7];
            pitch_clamped <= clamp_flag;
            out_valid     <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_yaw_range: assert property (@(posedge clk) disable iff (rst)
    yaw < YAW_W'(FULL_TURN))
    else $error("yaw angle out of range");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    (pitch <= P_LIM) && (pitch >= -P_LIM))
    else $error("pitch angle beyond limit");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < divisor))
    else $error("divider remainder not below divisor");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken but core not busy");

  a_result_from_flush: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_FLUSH))
    else $error("result presented outside flush");

endmodule
